// ===== rtl/multi_table_rans_encoder_assert.svh =====
// Assertion macros shared by the encoder RTL.
`ifndef MULTI_TABLE_RANS_ENCODER_ASSERT_SVH
`define MULTI_TABLE_RANS_ENCODER_ASSERT_SVH

// Same-cycle implication, clocked on clk_i, quiet while rst_ni is low.
`define MTRANS_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, clocked on clk_i, quiet while rst_ni is low.
`define MTRANS_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== rtl/mtrans_pkg.sv =====
// Types, codes and defaults of the multi-table rANS encoder.
package mtrans_pkg;

  // Default configuration
  localparam int unsigned NUM_TABLES_DEF     = 6;
  localparam int unsigned PRECISION_BITS_DEF = 14;

  // Coder constants
  localparam logic [31:0] STATE_LOW_BOUND = 32'h0001_0000;
  localparam int unsigned WORD_BITS       = 16;
  localparam int unsigned FREQ_W          = 15;
  localparam int unsigned CUM_W           = 14;

  // Command modes
  localparam logic [1:0] MODE_LOAD   = 2'd0;
  localparam logic [1:0] MODE_ENCODE = 2'd1;
  localparam logic [1:0] MODE_FLUSH  = 2'd2;

  // Result kinds
  localparam logic [1:0] KIND_WORD    = 2'd0;
  localparam logic [1:0] KIND_STATE_A = 2'd1;
  localparam logic [1:0] KIND_STATE_B = 2'd2;
  localparam logic [1:0] KIND_ERROR   = 2'd3;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_CHECK,
    ST_DIV,
    ST_FLUSH
  } state_e;

  typedef struct packed {
    logic [1:0]        mode;
    logic [2:0]        table_index;
    logic [7:0]        symbol;
    logic [FREQ_W-1:0] frequency;
    logic [CUM_W-1:0]  cumulative;
  } cmd_t;

  typedef struct packed {
    logic [1:0]  kind;
    logic [31:0] value;
    logic        last;
  } res_t;

  typedef struct packed {
    logic [FREQ_W-1:0] freq;
    logic [CUM_W-1:0]  cum;
  } entry_t;

  // Table port control
  typedef struct packed {
    logic   we;
    logic   re;
    entry_t wdata;
  } tbl_req_t;

endpackage

// ===== rtl/mtrans_tbl.sv =====
// Frequency and cumulative table memory, one write or read port, registered read.
module mtrans_tbl #(
  parameter int unsigned NUM_TABLES = mtrans_pkg::NUM_TABLES_DEF,
  parameter int unsigned ADDR_W     = $clog2(NUM_TABLES * 256)
) (
  input  logic                clk_i,
  input  mtrans_pkg::tbl_req_t req_i,
  input  logic [ADDR_W-1:0]   addr_i,
  output mtrans_pkg::entry_t  rdata_o
);
  import mtrans_pkg::*;

  localparam int unsigned DEPTH = NUM_TABLES * 256;

  entry_t mem [DEPTH];
  entry_t rdata_q;

  // Write port
  always_ff @(posedge clk_i) begin
    if (req_i.we) begin
      mem[addr_i] <= req_i.wdata;
    end
  end

  // Registered read, held until the next read
  always_ff @(posedge clk_i) begin
    if (req_i.re) begin
      rdata_q <= mem[addr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

// ===== rtl/mtrans_div.sv =====
// Radix-2 restoring divider, one quotient bit per cycle.
module mtrans_div #(
  parameter int unsigned QBITS = 32 - mtrans_pkg::PRECISION_BITS_DEF
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          start_i,
  input  logic [31:0]                   dividend_i,
  input  logic [mtrans_pkg::FREQ_W-1:0] divisor_i,
  output logic                          done_o,
  output logic [QBITS-1:0]              quot_o,
  output logic [mtrans_pkg::FREQ_W-1:0] rem_o
);
  import mtrans_pkg::*;

  localparam int unsigned CNT_W = $clog2(QBITS);

  logic              active_q;
  logic              done_q;
  logic [CNT_W-1:0]  cnt_q;
  logic [31:0]       sh_q;
  logic [FREQ_W-1:0] rem_q;
  logic [FREQ_W-1:0] dvs_q;
  logic [FREQ_W:0]   trial;
  logic              ge;

  // Trial subtract: partial remainder with the next dividend bit
  assign trial = {rem_q, sh_q[31]};
  assign ge    = trial >= {1'b0, dvs_q};

  // Control
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      active_q <= 1'b0;
      done_q   <= 1'b0;
      cnt_q    <= '0;
    end else begin
      done_q <= 1'b0;
      if (start_i) begin
        active_q <= 1'b1;
        cnt_q    <= '0;
      end else if (active_q) begin
        cnt_q <= cnt_q + 1'b1;
        if (cnt_q == CNT_W'(QBITS - 1)) begin
          active_q <= 1'b0;
          done_q   <= 1'b1;
        end
      end
    end
  end

  // Datapath: quotient bits shift in at the bottom of the dividend register
  always_ff @(posedge clk_i) begin
    if (start_i) begin
      sh_q  <= dividend_i << (32 - QBITS);
      rem_q <= FREQ_W'(dividend_i >> QBITS);
      dvs_q <= divisor_i;
    end else if (active_q) begin
      sh_q  <= {sh_q[30:0], ge};
      rem_q <= ge ? FREQ_W'(trial - {1'b0, dvs_q}) : trial[FREQ_W-1:0];
    end
  end

  assign done_o = done_q;
  assign quot_o = sh_q[QBITS-1:0];
  assign rem_o  = rem_q;

endmodule

// ===== rtl/multi_table_rans_encoder.sv =====
// Two-state interleaved rANS encoder with selectable frequency tables.
//
// Command channel: a word on cmd_i is taken at a rising edge with start_i high
// and busy_o low. Mode 0 writes one table entry in that cycle and leaves the
// block free (busy_o stays low). Mode 1 encodes one symbol; mode 2 flushes.
// Result channel: each result word sits on res_o for one cycle with
// res_valid_o high; the receiver has no way to stall it.
// Encode: the table entry is read into a register, then the check state gives
// a renormalization word, or an error word for a zero frequency or a table
// index out of range; the state update waits for the divider and for its
// registered done flag. busy_o stays high until the state update, or after
// an error until the check state ends; a new symbol is taken only once
// busy_o is low again.
// Flush: the first final state is registered onto res_o at acceptance and
// the second, with last set, follows from the flush state.
// Reset: both coder states return to 65536 and the first state is next.
// The table memory is not cleared: entries are undefined until loaded.
module multi_table_rans_encoder #(
  parameter int unsigned NUM_TABLES     = mtrans_pkg::NUM_TABLES_DEF,
  parameter int unsigned PRECISION_BITS = mtrans_pkg::PRECISION_BITS_DEF
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             start_i,
  input  mtrans_pkg::cmd_t cmd_i,
  output logic             busy_o,
  output logic             res_valid_o,
  output mtrans_pkg::res_t res_o
);
  import mtrans_pkg::*;

  localparam int unsigned ADDR_W = $clog2(NUM_TABLES * 256);
  localparam int unsigned QBITS  = 32 - PRECISION_BITS;
  localparam int unsigned BND_W  = 32 + FREQ_W;

  state_e            state_q, state_d;
  logic [31:0]       st_a_q, st_a_d;
  logic [31:0]       st_b_q, st_b_d;
  logic              use_second_q, use_second_d;
  logic              bad_q, bad_d;
  logic              res_valid_q, res_valid_d;
  res_t              res_q, res_d;

  logic              accept;
  logic              in_range;
  tbl_req_t          tbl_req;
  logic [ADDR_W-1:0] tbl_addr;
  entry_t            entry;

  logic [31:0]       x_cur;
  logic              renorm;
  logic [31:0]       dividend;
  logic              div_start;
  logic              div_done;
  logic [QBITS-1:0]  quot;
  logic [FREQ_W-1:0] rem;
  logic [31:0]       x_new;

  assign accept   = start_i && (state_q == ST_IDLE);
  assign in_range = 32'(cmd_i.table_index) < NUM_TABLES;

  // Table access: loads write at once, encodes read for the check cycle
  assign tbl_req.we    = accept && (cmd_i.mode == MODE_LOAD) && in_range;
  assign tbl_req.re    = accept && (cmd_i.mode == MODE_ENCODE) && in_range;
  assign tbl_req.wdata = '{freq: cmd_i.frequency, cum: cmd_i.cumulative};
  assign tbl_addr      = ADDR_W'({cmd_i.table_index, cmd_i.symbol});

  mtrans_tbl #(
    .NUM_TABLES (NUM_TABLES),
    .ADDR_W     (ADDR_W)
  ) u_tbl (
    .clk_i   (clk_i),
    .req_i   (tbl_req),
    .addr_i  (tbl_addr),
    .rdata_o (entry)
  );

  // Renormalization test: x >= f << (32 - PRECISION_BITS)
  assign x_cur    = use_second_q ? st_b_q : st_a_q;
  assign renorm   = BND_W'(x_cur) >= (BND_W'(entry.freq) << QBITS);
  assign dividend = renorm ? (x_cur >> WORD_BITS) : x_cur;

  mtrans_div #(
    .QBITS (QBITS)
  ) u_div (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (div_start),
    .dividend_i (dividend),
    .divisor_i  (entry.freq),
    .done_o     (div_done),
    .quot_o     (quot),
    .rem_o      (rem)
  );

  // New state: (q << PRECISION_BITS) + c + r
  assign x_new = {quot, {PRECISION_BITS{1'b0}}} + 32'(entry.cum) + 32'(rem);

  // Sequencer
  always_comb begin
    state_d      = state_q;
    st_a_d       = st_a_q;
    st_b_d       = st_b_q;
    use_second_d = use_second_q;
    bad_d        = bad_q;
    res_valid_d  = 1'b0;
    res_d        = res_q;
    div_start    = 1'b0;
    case (state_q)
      ST_IDLE: begin
        if (start_i) begin
          case (cmd_i.mode)
            MODE_ENCODE: begin
              bad_d   = !in_range;
              state_d = ST_CHECK;
            end
            MODE_FLUSH: begin
              res_valid_d = 1'b1;
              res_d       = '{kind: KIND_STATE_A, value: st_a_q, last: 1'b0};
              state_d     = ST_FLUSH;
            end
            default: ;
          endcase
        end
      end
      ST_CHECK: begin
        if (bad_q || (entry.freq == '0)) begin
          res_valid_d = 1'b1;
          res_d       = '{kind: KIND_ERROR, value: '0, last: 1'b0};
          state_d     = ST_IDLE;
        end else begin
          if (renorm) begin
            res_valid_d = 1'b1;
            res_d       = '{kind: KIND_WORD, value: {16'h0, x_cur[15:0]}, last: 1'b0};
          end
          div_start = 1'b1;
          state_d   = ST_DIV;
        end
      end
      ST_DIV: begin
        if (div_done) begin
          if (use_second_q) begin
            st_b_d = x_new;
          end else begin
            st_a_d = x_new;
          end
          use_second_d = !use_second_q;
          state_d      = ST_IDLE;
        end
      end
      ST_FLUSH: begin
        res_valid_d  = 1'b1;
        res_d        = '{kind: KIND_STATE_B, value: st_b_q, last: 1'b1};
        st_a_d       = STATE_LOW_BOUND;
        st_b_d       = STATE_LOW_BOUND;
        use_second_d = 1'b0;
        state_d      = ST_IDLE;
      end
      default: state_d = ST_IDLE;
    endcase
  end

  // Control and coder state registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q      <= ST_IDLE;
      st_a_q       <= STATE_LOW_BOUND;
      st_b_q       <= STATE_LOW_BOUND;
      use_second_q <= 1'b0;
      bad_q        <= 1'b0;
      res_valid_q  <= 1'b0;
    end else begin
      state_q      <= state_d;
      st_a_q       <= st_a_d;
      st_b_q       <= st_b_d;
      use_second_q <= use_second_d;
      bad_q        <= bad_d;
      res_valid_q  <= res_valid_d;
    end
  end

  // Result word register
  always_ff @(posedge clk_i) begin
    res_q <= res_d;
  end

  assign busy_o      = state_q != ST_IDLE;
  assign res_valid_o = res_valid_q;
  assign res_o       = res_q;

  `include "multi_table_rans_encoder_assert.svh"

  `MTRANS_ASSERT_NEXT(a_flush_pair, res_valid_o && (res_o.kind == KIND_STATE_A),
                      res_valid_o && (res_o.kind == KIND_STATE_B) && res_o.last,
                      "flush did not give the second state next")
  `MTRANS_ASSERT_NOW(a_last_only_b, res_valid_o && res_o.last,
                     res_o.kind == KIND_STATE_B,
                     "last set on a word other than the second state")
  `MTRANS_ASSERT_NOW(a_word_narrow, res_valid_o && (res_o.kind == KIND_WORD),
                     res_o.value[31:16] == 16'h0,
                     "renormalization word wider than 16 bits")
  `MTRANS_ASSERT_NEXT(a_div_update, (state_q == ST_DIV) && div_done,
                      (state_q == ST_IDLE) && (use_second_q != $past(use_second_q)),
                      "divider done without state turn")

endmodule

// ===== sim/tb_multi_table_rans_encoder.sv =====
// Self-checking testbench for the multi-table rANS encoder: command words in, coded words out.
`timescale 1ns / 1ps

module tb_multi_table_rans_encoder;
  import mtrans_pkg::*;

  localparam int unsigned NUM_TBL = NUM_TABLES_DEF;
  localparam int unsigned PREC    = PRECISION_BITS_DEF;
  localparam int unsigned ENTRIES = NUM_TBL * 256;

  logic clk_i;
  logic rst_ni;
  logic start_i;
  cmd_t cmd_i;
  logic busy_o;
  logic res_valid_o;
  res_t res_o;

  multi_table_rans_encoder dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .start_i     (start_i),
    .cmd_i       (cmd_i),
    .busy_o      (busy_o),
    .res_valid_o (res_valid_o),
    .res_o       (res_o)
  );

  // Predicted coder contents
  logic [FREQ_W-1:0] freq_mem [ENTRIES];
  logic [CUM_W-1:0]  cum_mem  [ENTRIES];
  bit                loaded   [ENTRIES];
  int unsigned       loaded_cnt [NUM_TBL];
  logic [31:0]       state_a;
  logic [31:0]       state_b;
  bit                second_next;

  res_t        coder_out_q [$];
  res_t        exp_w;
  int unsigned mismatches;
  int unsigned n_sent;
  bit          idle_en;

  // Clock
  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  // Run limit
  initial begin
    #5_000_000;
    $display("Testbench completed WITH ERRORS");
    $finish;
  end

  function automatic cmd_t make_cmd(logic [1:0] m, int unsigned t, int unsigned s,
                                    int unsigned f, int unsigned cu);
    make_cmd.mode        = m;
    make_cmd.table_index = 3'(t);
    make_cmd.symbol      = 8'(s);
    make_cmd.frequency   = FREQ_W'(f);
    make_cmd.cumulative  = CUM_W'(cu);
  endfunction

  function automatic res_t make_res(logic [1:0] k, logic [31:0] v, logic l);
    make_res.kind  = k;
    make_res.value = v;
    make_res.last  = l;
  endfunction

  // Works out the coded words one accepted command gives, and updates the coder copy
  task automatic rans_predict(input cmd_t c);
    logic [10:0] idx;
    logic [63:0] x, f, lim, q, r;
    idx = {c.table_index, c.symbol};
    case (c.mode)
      MODE_LOAD: begin
        if (c.table_index < NUM_TBL) begin
          if (!loaded[idx]) loaded_cnt[c.table_index]++;
          loaded[idx]   = 1'b1;
          freq_mem[idx] = c.frequency;
          cum_mem[idx]  = c.cumulative;
        end
      end
      MODE_ENCODE: begin
        f = 64'd0;
        if (c.table_index < NUM_TBL) f = 64'(freq_mem[idx]);
        if (f == 64'd0) begin
          coder_out_q.push_back(make_res(KIND_ERROR, 32'd0, 1'b0));
        end else begin
          x   = second_next ? 64'(state_b) : 64'(state_a);
          lim = ((64'(STATE_LOW_BOUND) >> PREC) << WORD_BITS) * f;
          // at most one 16-bit word leaves per symbol
          if (x >= lim) begin
            coder_out_q.push_back(make_res(KIND_WORD, {16'h0000, x[15:0]}, 1'b0));
            x = x >> WORD_BITS;
          end
          q = x / f;
          r = x % f;
          x = (q << PREC) + 64'(cum_mem[idx]) + r;
          if (second_next) state_b = x[31:0];
          else state_a = x[31:0];
          second_next = !second_next;
        end
      end
      MODE_FLUSH: begin
        coder_out_q.push_back(make_res(KIND_STATE_A, state_a, 1'b0));
        coder_out_q.push_back(make_res(KIND_STATE_B, state_b, 1'b1));
        state_a     = STATE_LOW_BOUND;
        state_b     = STATE_LOW_BOUND;
        second_next = 1'b0;
      end
      default: ;
    endcase
  endtask

  // Sends one command word; an optional idle burst comes first
  task automatic send_word(input cmd_t c);
    int unsigned gap;
    if (idle_en && $urandom_range(0, 3) == 0) begin
      gap = $urandom_range(1, 7);
      @(negedge clk_i);
      start_i = 1'b0;
      repeat (gap - 1) @(negedge clk_i);
    end
    @(negedge clk_i);
    start_i = 1'b1;
    cmd_i   = c;
    forever begin
      @(posedge clk_i);
      if (!busy_o) break;
    end
    rans_predict(c);
    n_sent++;
  endtask

  // Picks a loaded entry, starting from a random table and symbol
  function automatic bit pick_entry(output logic [2:0] t, output logic [7:0] s);
    int unsigned t0, s0;
    bit found;
    t0 = $urandom_range(0, NUM_TBL - 1);
    s0 = $urandom_range(0, 255);
    found = 1'b0;
    t = '0;
    s = '0;
    for (int i = 0; i < NUM_TBL && !found; i++) begin
      t = 3'((t0 + i) % NUM_TBL);
      if (loaded_cnt[t] != 0) begin
        for (int j = 0; j < 256 && !found; j++) begin
          s = 8'((s0 + j) % 256);
          found = loaded[{t, s}];
        end
      end
    end
    return found;
  endfunction

  // Loads a normalized table: frequencies sum to 1<<PREC, cumulatives follow
  task automatic load_table();
    int unsigned t, n, left, f, acc, s;
    bit taken [256];
    t    = $urandom_range(0, NUM_TBL - 1);
    n    = ($urandom_range(0, 7) == 0) ? 1 : $urandom_range(2, 20);
    left = 1 << PREC;
    acc  = 0;
    for (int i = 0; i < 256; i++) taken[i] = 1'b0;
    for (int i = 0; i < n; i++) begin
      if (i == n - 1) begin
        f = left;
      end else begin
        f = $urandom_range(1, 2 * left / (n - i));
        if (f > left - (n - 1 - i)) f = left - (n - 1 - i);
      end
      s = $urandom_range(0, 255);
      while (taken[s]) s = (s + 1) % 256;
      taken[s] = 1'b1;
      send_word(make_cmd(MODE_LOAD, t, s, f, acc));
      acc  += f;
      left -= f;
    end
    // a few absent symbols
    repeat ($urandom_range(0, 2)) begin
      s = $urandom_range(0, 255);
      while (taken[s]) s = (s + 1) % 256;
      taken[s] = 1'b1;
      send_word(make_cmd(MODE_LOAD, t, s, 0, $urandom_range(0, 16383)));
    end
  endtask

  // One encode, or now and then a stray or ignored word
  task automatic encode_or_noise();
    logic [2:0] t;
    logic [7:0] s;
    if ($urandom_range(0, 24) == 0 || !pick_entry(t, s)) begin
      case ($urandom_range(0, 3))
        0: send_word(make_cmd(2'd3, $urandom_range(0, 7), $urandom_range(0, 255),
                              $urandom_range(0, 16384), $urandom_range(0, 16383)));
        1: send_word(make_cmd(MODE_LOAD, $urandom_range(NUM_TBL, 7), $urandom_range(0, 255),
                              $urandom_range(0, 16384), $urandom_range(0, 16383)));
        2: send_word(make_cmd(MODE_ENCODE, $urandom_range(NUM_TBL, 7),
                              $urandom_range(0, 255), $urandom_range(0, 16384),
                              $urandom_range(0, 16383)));
        default: send_word(make_cmd(MODE_LOAD, $urandom_range(0, NUM_TBL - 1),
                                    $urandom_range(0, 255), $urandom_range(0, 16384),
                                    $urandom_range(0, 16383)));
      endcase
    end else begin
      send_word(make_cmd(MODE_ENCODE, t, s, $urandom_range(0, 16384),
                         $urandom_range(0, 16383)));
    end
  endtask

  task automatic traffic_round();
    if ($urandom_range(0, 2) == 0) load_table();
    repeat ($urandom_range(10, 60)) encode_or_noise();
    if ($urandom_range(0, 1) == 0)
      send_word(make_cmd(MODE_FLUSH, $urandom_range(0, 7), $urandom_range(0, 255),
                         $urandom_range(0, 16384), $urandom_range(0, 16383)));
  endtask

  // Directed tests
  task automatic test_flush_after_reset();
    send_word(make_cmd(MODE_FLUSH, 0, 0, 0, 0));
  endtask

  task automatic test_table_extremes();
    send_word(make_cmd(MODE_LOAD, 0, 0, 16384, 0));
    send_word(make_cmd(MODE_LOAD, 5, 255, 1, 16383));
    send_word(make_cmd(MODE_LOAD, 1, 8'h55, 16383, 14'h2AAA));
    send_word(make_cmd(MODE_LOAD, 3, 8'hAA, 0, 0));
    send_word(make_cmd(MODE_ENCODE, 0, 0, 0, 0));
    // unit frequency grows the states fast; the third hit renormalizes
    send_word(make_cmd(MODE_ENCODE, 5, 255, 16384, 16383));
    send_word(make_cmd(MODE_ENCODE, 5, 255, 0, 0));
    send_word(make_cmd(MODE_ENCODE, 5, 255, 0, 0));
    send_word(make_cmd(MODE_ENCODE, 1, 8'h55, 16383, 0));
  endtask

  task automatic test_error_cases();
    send_word(make_cmd(MODE_ENCODE, 3, 8'hAA, 0, 0));
    send_word(make_cmd(MODE_ENCODE, 7, 0, 0, 0));
    send_word(make_cmd(MODE_ENCODE, 6, 255, 16384, 16383));
    send_word(make_cmd(MODE_LOAD, 6, 1, 5, 5));
    send_word(make_cmd(MODE_LOAD, 7, 255, 16384, 16383));
    send_word(make_cmd(2'd3, 7, 255, 16384, 16383));
  endtask

  task automatic test_flush_restart();
    send_word(make_cmd(MODE_FLUSH, 7, 255, 16383, 16383));
    send_word(make_cmd(MODE_ENCODE, 0, 0, 0, 0));
    send_word(make_cmd(MODE_ENCODE, 1, 8'h55, 0, 0));
    send_word(make_cmd(MODE_FLUSH, 0, 0, 0, 0));
  endtask

  // Random tests
  task automatic test_random_traffic();
    idle_en = 1'b1;
    while (n_sent < 1150) traffic_round();
  endtask

  task automatic test_back_to_back();
    int unsigned target;
    target  = n_sent + 200;
    idle_en = 1'b0;
    while (n_sent < target) traffic_round();
    send_word(make_cmd(MODE_FLUSH, 0, 0, 0, 0));
  endtask

  // Result checker
  always @(posedge clk_i) begin
    if (rst_ni && res_valid_o) begin
      if (coder_out_q.size() == 0) begin
        $error("unexpected word: kind %0d value %0h last %0d",
               res_o.kind, res_o.value, res_o.last);
        mismatches++;
      end else begin
        exp_w = coder_out_q.pop_front();
        if (res_o.kind !== exp_w.kind) begin
          $error("kind: expected %0d, got %0d", exp_w.kind, res_o.kind);
          mismatches++;
        end
        if (res_o.value !== exp_w.value) begin
          $error("value: expected %0h, got %0h", exp_w.value, res_o.value);
          mismatches++;
        end
        if (res_o.last !== exp_w.last) begin
          $error("last: expected %0d, got %0d", exp_w.last, res_o.last);
          mismatches++;
        end
      end
    end
  end

  // Main sequence
  initial begin
    rst_ni      = 1'b0;
    start_i     = 1'b0;
    cmd_i       = '0;
    idle_en     = 1'b1;
    mismatches  = 0;
    n_sent      = 0;
    state_a     = STATE_LOW_BOUND;
    state_b     = STATE_LOW_BOUND;
    second_next = 1'b0;
    for (int i = 0; i < ENTRIES; i++) loaded[i] = 1'b0;
    for (int i = 0; i < NUM_TBL; i++) loaded_cnt[i] = 0;
    repeat (9) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    test_flush_after_reset();
    test_table_extremes();
    test_error_cases();
    test_flush_restart();
    test_random_traffic();
    test_back_to_back();

    @(negedge clk_i);
    start_i = 1'b0;
    while (coder_out_q.size() != 0) @(posedge clk_i);
    repeat (40) @(posedge clk_i);
    if (mismatches == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

endmodule

// ===== sim.f =====
+incdir+rtl
rtl/mtrans_pkg.sv
rtl/mtrans_tbl.sv
rtl/mtrans_div.sv
rtl/multi_table_rans_encoder.sv
sim/tb_multi_table_rans_encoder.sv
